// ----- sv/hfb_pkg.sv -----
// Shared types and constants of the boundary hole fill block.
`default_nettype none
package hfb_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;

	localparam int VAL_W      = 32;
	localparam int ACC_W      = 48;
	localparam int CNT_W      = 17;
	localparam int IDX_W      = 14;
	localparam int DIM_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
	localparam logic signed [VAL_W-1:0] VAL_TOP = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_BOT = {1'b1, {(VAL_W-1){1'b0}}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Combine modes; every other code sums for the mean.
	localparam logic [1:0] MODE_MIN = 2'd0;
	localparam logic [1:0] MODE_MAX = 2'd1;

	// Input operations.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Neighbor directions.
	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	// Read address source of the pixel side memories.
	localparam logic [1:0] ASEL_NONE = 2'd0;
	localparam logic [1:0] ASEL_RD   = 2'd1;
	localparam logic [1:0] ASEL_P    = 2'd2;
	localparam logic [1:0] ASEL_NB   = 2'd3;

	typedef struct packed {
		logic       load;
		logic       out_ld;
		logic [1:0] asel;
		logic [1:0] dir;
		logic       scan_rst;
		logic       step;
		logic       flip;
		logic       init_wr;
		logic       lat_px;
		logic       lat_nb;
		logic       prop_wr;
		logic       root_rd;
		logic       acc_ld;
		logic       fold;
		logic       acc_wr;
		logic       div_go;
		logic       fill_wr;
		logic       pos_clr;
	} cmd_t;

	typedef struct packed {
		logic at_end;
		logic fwd;
		logic miss;
		logic lower;
		logic div_need;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- sv/hfb_if.sv -----
// Channel interfaces: pixel input, pixel output and configuration write.
`default_nettype none
interface hfb_in_if import hfb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic signed [VAL_W-1:0] pixel_value;
	logic                    pixel_missing;
	logic                    last_pixel;
	logic [IDX_W-1:0]        read_index;

	modport source(output valid, op, pixel_value, pixel_missing, last_pixel, read_index,
		input ready);
	modport sink(input valid, op, pixel_value, pixel_missing, last_pixel, read_index,
		output ready);
endinterface

interface hfb_out_if import hfb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic                    was_filled;
	logic                    no_boundary;

	modport source(output valid, out_value, was_filled, no_boundary, input ready);
	modport sink(input valid, out_value, was_filled, no_boundary, output ready);
endinterface

interface hfb_cfg_if import hfb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/image_hole_fill_boundary_top.sv -----
// Top level of the boundary hole fill block: controller, datapath and channel wiring.
//
//   channel   role    beat carries
//   pix_in    sink    op, pixel_value, pixel_missing, last_pixel, read_index
//   pix_out   source  out_value, was_filled, no_boundary (one beat per read)
//   cfg       sink    index, data (always ready)
//
// A load is written in the idle state; a read registers the addressed pixel and then
// waits in the read state only while the output register is still full. A load with
// last_pixel starts the fill, during which no beat is accepted: label setup, label
// sweeps (at least two), border accumulation over each hole pixel, and the fill of
// each hole pixel (with a division in mean mode when the hole has a border). The mean
// divider retires one quotient bit per cycle. Reset needs no clearing pass.
`default_nettype none
module image_hole_fill_boundary_top import hfb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hfb_in_if.sink    pix_in,
	hfb_out_if.source pix_out,
	hfb_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	hfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_op    (pix_in.op),
		.in_last  (pix_in.last_pixel),
		.in_ready (pix_in.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	hfb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.pixel_value   (pix_in.pixel_value),
		.pixel_missing (pix_in.pixel_missing),
		.read_index    (pix_in.read_index),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.cfg_ready     (cfg.ready),
		.out_ready     (pix_out.ready),
		.out_valid     (pix_out.valid),
		.out_value     (pix_out.out_value),
		.was_filled    (pix_out.was_filled),
		.no_boundary   (pix_out.no_boundary)
	);

endmodule
`default_nettype wire

// ----- sv/hfb_div.sv -----
// Iterative signed by unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module hfb_div import hfb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    busy,
	output logic [VAL_W-1:0]        quotient
);

	localparam int STEP_W = $clog2(ACC_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] steps_q;
	logic              neg_q;
	logic [ACC_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;
	logic [ACC_W-1:0]  quo_signed;

	assign rem_sh     = {rem_q, quo_q[ACC_W-1]};
	assign fits       = rem_sh >= {1'b0, den_q};
	assign quo_signed = neg_q ? (~quo_q + {{(ACC_W-1){1'b0}}, 1'b1}) : quo_q;
	assign quotient   = quo_signed[VAL_W-1:0];
	assign busy       = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			steps_q <= STEP_W'(ACC_W);
		end else if (busy_q) begin
			steps_q <= steps_q - STEP_W'(1);
			if (steps_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			quo_q <= dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			// Restoring step: the partial remainder always stays below the divisor.
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, den_q}) : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// ----- sv/hfb_dp.sv -----
// Datapath: configuration, image stores, scan counters, region accumulation and output register.
`default_nettype none
module hfb_dp import hfb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic signed [VAL_W-1:0] pixel_value,
	input  logic                    pixel_missing,
	input  logic [IDX_W-1:0]        read_index,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    cfg_ready,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    was_filled,
	output logic                    no_boundary
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	// Configuration.
	logic [1:0]       mode_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [2*DIM_W-1:0] n_full;
	logic [NW-1:0]    n_px;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_MIN;
			width_q  <= DIM_W'(128);
			height_q <= DIM_W'(128);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)                   w_eff = DIM_W'(1);
		else if (32'(width_q) > MAX_WIDTH)   w_eff = DIM_W'(MAX_WIDTH);
		else                                 w_eff = width_q;
		if (height_q == '0)                  h_eff = DIM_W'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
		else                                 h_eff = height_q;
		n_full = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
		n_px   = NW'(n_full);
	end

	// Scan position over the image, walking forward or backward.
	logic [AW-1:0]    p_q;
	logic [DIM_W-1:0] r_q, c_q;
	logic             fwd_q;
	logic [NW-1:0]    pos_q;

	assign sts.fwd    = fwd_q;
	assign sts.at_end = fwd_q ? (r_q == h_eff - DIM_W'(1) && c_q == w_eff - DIM_W'(1))
	                          : (r_q == '0 && c_q == '0);

	logic load_we;
	assign load_we = cmd.load && (pos_q < n_px);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= '0;
			r_q   <= '0;
			c_q   <= '0;
			fwd_q <= 1'b1;
			pos_q <= '0;
		end else begin
			if (load_we) begin
				pos_q <= pos_q + NW'(1);
			end else if (cmd.pos_clr) begin
				pos_q <= '0;
			end
			if (cmd.scan_rst) begin
				p_q   <= '0;
				r_q   <= '0;
				c_q   <= '0;
				fwd_q <= 1'b1;
			end else begin
				if (cmd.flip) begin
					fwd_q <= !fwd_q;
				end
				if (cmd.step) begin
					if (fwd_q) begin
						p_q <= p_q + AW'(1);
						if (c_q == w_eff - DIM_W'(1)) begin
							c_q <= '0;
							r_q <= r_q + DIM_W'(1);
						end else begin
							c_q <= c_q + DIM_W'(1);
						end
					end else begin
						p_q <= p_q - AW'(1);
						if (c_q == '0) begin
							c_q <= w_eff - DIM_W'(1);
							r_q <= r_q - DIM_W'(1);
						end else begin
							c_q <= c_q - DIM_W'(1);
						end
					end
				end
			end
		end
	end

	// Neighbor address and whether it lies inside the image.
	logic [AW-1:0] nb_addr;
	logic          nb_ok;
	logic [AW-1:0] addr_a;
	logic          re_a;

	always_comb begin
		unique case (cmd.dir)
			DIR_RIGHT: begin
				nb_addr = p_q + AW'(1);
				nb_ok   = c_q != w_eff - DIM_W'(1);
			end
			DIR_LEFT: begin
				nb_addr = p_q - AW'(1);
				nb_ok   = c_q != '0;
			end
			DIR_DOWN: begin
				nb_addr = p_q + AW'(w_eff);
				nb_ok   = r_q != h_eff - DIM_W'(1);
			end
			default: begin
				nb_addr = p_q - AW'(w_eff);
				nb_ok   = r_q != '0;
			end
		endcase
		unique case (cmd.asel)
			ASEL_RD: addr_a = AW'(read_index);
			ASEL_NB: addr_a = nb_addr;
			default: addr_a = p_q;
		endcase
		re_a = cmd.asel != ASEL_NONE;
	end

	// Stores.
	logic signed [VAL_W-1:0] pix_mem [DEPTH];
	logic                    miss_mem [DEPTH];
	logic                    nob_mem [DEPTH];
	logic [AW-1:0]           lab_mem [DEPTH];
	logic signed [ACC_W-1:0] acc_mem [DEPTH];
	logic [CNT_W-1:0]        cnt_mem [DEPTH];

	logic signed [VAL_W-1:0] pix_rd;
	logic                    miss_rd;
	logic                    nob_rd;
	logic [AW-1:0]           lab_rd;
	logic signed [ACC_W-1:0] acc_rd;
	logic [CNT_W-1:0]        cnt_rd;

	logic [AW-1:0]           pos_a;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [AW-1:0]           root_q;
	logic signed [VAL_W-1:0] fill_val;
	logic                    div_use;
	logic [VAL_W-1:0]        div_q;
	logic                    div_busy;
	logic signed [ACC_W-1:0] acc_init;
	logic [AW-1:0]           lp_q, cand_q, cand_nx;
	logic                    mp_q, nv_q, nb_take;

	assign pos_a = pos_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (load_we) begin
			pix_mem[pos_a] <= pixel_value;
		end else if (cmd.fill_wr) begin
			pix_mem[p_q] <= fill_val;
		end
		if (re_a) begin
			pix_rd <= pix_mem[addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			miss_mem[pos_a] <= pixel_missing;
		end
		if (re_a) begin
			miss_rd <= miss_mem[addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			nob_mem[pos_a] <= 1'b0;
		end else if (cmd.fill_wr) begin
			nob_mem[p_q] <= cnt_q == '0;
		end
		if (re_a) begin
			nob_rd <= nob_mem[addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			lab_mem[p_q] <= p_q;
		end else if (cmd.prop_wr && sts.lower) begin
			lab_mem[p_q] <= cand_nx;
		end
		if (re_a) begin
			lab_rd <= lab_mem[addr_a];
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_MIN: acc_init = ACC_W'(VAL_TOP);
			MODE_MAX: acc_init = ACC_W'(VAL_BOT);
			default:  acc_init = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			acc_mem[p_q] <= acc_init;
			cnt_mem[p_q] <= '0;
		end else if (cmd.acc_wr) begin
			acc_mem[root_q] <= acc_q;
			cnt_mem[root_q] <= cnt_q;
		end
		if (cmd.root_rd) begin
			acc_rd <= acc_mem[lab_rd];
			cnt_rd <= cnt_mem[lab_rd];
		end
	end

	// Propagation: a missing pixel takes the least label of itself and missing back neighbors.
	assign nb_take   = nv_q && miss_rd && (lab_rd < cand_q);
	assign cand_nx   = nb_take ? lab_rd : cand_q;
	assign sts.lower = mp_q && (cand_nx < lp_q);
	assign sts.miss  = miss_rd;

	// Border accumulation of one region.
	logic signed [ACC_W-1:0] pv;
	logic signed [ACC_W-1:0] acc_fold;

	assign pv = ACC_W'(pix_rd);

	always_comb begin
		unique case (mode_q)
			MODE_MIN: acc_fold = (pv < acc_q) ? pv : acc_q;
			MODE_MAX: acc_fold = (pv > acc_q) ? pv : acc_q;
			default:  acc_fold = acc_q + pv;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_px) begin
			mp_q   <= miss_rd;
			lp_q   <= lab_rd;
			cand_q <= lab_rd;
		end else if (cmd.lat_nb) begin
			cand_q <= cand_nx;
		end
		if (cmd.asel == ASEL_NB) begin
			nv_q <= nb_ok;
		end
		if (cmd.root_rd) begin
			root_q <= lab_rd;
		end
		if (cmd.acc_ld) begin
			acc_q <= acc_rd;
			cnt_q <= cnt_rd;
		end else if (cmd.fold && nv_q && !miss_rd) begin
			acc_q <= acc_fold;
			if (cnt_q != CNT_SAT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Fill value.
	assign sts.div_need = (mode_q != MODE_MIN) && (mode_q != MODE_MAX) && (cnt_rd != '0);
	assign sts.div_done = !div_busy;
	assign div_use      = (mode_q != MODE_MIN) && (mode_q != MODE_MAX) && (cnt_q != '0);
	assign fill_val     = div_use ? $signed(div_q) : acc_q[VAL_W-1:0];

	hfb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (acc_rd),
		.divisor  (cnt_rd),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// Output register.
	logic                    out_valid_q;
	logic                    oor_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    was_filled_q;
	logic                    no_boundary_q;

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign was_filled   = was_filled_q;
	assign no_boundary  = no_boundary_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.asel == ASEL_RD) begin
			oor_q <= 32'(read_index) >= 32'(n_px);
		end
		if (cmd.out_ld) begin
			out_value_q   <= oor_q ? '0 : pix_rd;
			was_filled_q  <= oor_q ? 1'b0 : miss_rd;
			no_boundary_q <= oor_q ? 1'b0 : nob_rd;
		end
	end

endmodule
`default_nettype wire

// ----- sv/hfb_ctrl.sv -----
// Controller: input handshake and the sequence of labelling, accumulation and fill passes.
`default_nettype none
module hfb_ctrl import hfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	input  logic in_last,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RD   = 5'd1;
	localparam logic [4:0] S_INIT = 5'd2;
	localparam logic [4:0] S_P0   = 5'd3;
	localparam logic [4:0] S_P1   = 5'd4;
	localparam logic [4:0] S_P2   = 5'd5;
	localparam logic [4:0] S_P3   = 5'd6;
	localparam logic [4:0] S_A0   = 5'd7;
	localparam logic [4:0] S_A1   = 5'd8;
	localparam logic [4:0] S_A2   = 5'd9;
	localparam logic [4:0] S_A3   = 5'd10;
	localparam logic [4:0] S_A4   = 5'd11;
	localparam logic [4:0] S_F0   = 5'd12;
	localparam logic [4:0] S_F1   = 5'd13;
	localparam logic [4:0] S_F2   = 5'd14;
	localparam logic [4:0] S_F3   = 5'd15;
	localparam logic [4:0] S_F4   = 5'd16;

	logic [4:0] state_q, state_d;
	logic       chg_q, prev_q;
	logic [1:0] dir_q;
	logic       pass_chg;

	assign pass_chg = chg_q | sts.lower;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_LOAD) begin
						cmd.load = 1'b1;
						if (in_last) begin
							cmd.scan_rst = 1'b1;
							state_d      = S_INIT;
						end
					end else begin
						cmd.asel = ASEL_RD;
						state_d  = S_RD;
					end
				end
			end
			S_RD: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.at_end) begin
					cmd.flip = 1'b1;
					state_d  = S_P0;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_P0: begin
				cmd.asel = ASEL_P;
				state_d  = S_P1;
			end
			S_P1: begin
				cmd.lat_px = 1'b1;
				cmd.asel   = ASEL_NB;
				cmd.dir    = sts.fwd ? DIR_LEFT : DIR_RIGHT;
				state_d    = S_P2;
			end
			S_P2: begin
				cmd.lat_nb = 1'b1;
				cmd.asel   = ASEL_NB;
				cmd.dir    = sts.fwd ? DIR_UP : DIR_DOWN;
				state_d    = S_P3;
			end
			S_P3: begin
				cmd.prop_wr = 1'b1;
				if (sts.at_end) begin
					cmd.flip = 1'b1;
					// Two sweeps in a row without a change leave every region uniform.
					state_d  = (!pass_chg && !prev_q) ? S_A0 : S_P0;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_P0;
				end
			end
			S_A0: begin
				cmd.asel = ASEL_P;
				state_d  = S_A1;
			end
			S_A1: begin
				if (!sts.miss) begin
					if (sts.at_end) begin
						cmd.flip = 1'b1;
						state_d  = S_F0;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_A0;
					end
				end else begin
					cmd.root_rd = 1'b1;
					state_d     = S_A2;
				end
			end
			S_A2: begin
				cmd.acc_ld = 1'b1;
				cmd.asel   = ASEL_NB;
				cmd.dir    = DIR_RIGHT;
				state_d    = S_A3;
			end
			S_A3: begin
				cmd.fold = 1'b1;
				if (dir_q == DIR_UP) begin
					state_d = S_A4;
				end else begin
					cmd.asel = ASEL_NB;
					cmd.dir  = dir_q + 2'd1;
				end
			end
			S_A4: begin
				cmd.acc_wr = 1'b1;
				if (sts.at_end) begin
					cmd.flip = 1'b1;
					state_d  = S_F0;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_A0;
				end
			end
			S_F0: begin
				cmd.asel = ASEL_P;
				state_d  = S_F1;
			end
			S_F1: begin
				if (!sts.miss) begin
					if (sts.at_end) begin
						cmd.pos_clr = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_F0;
					end
				end else begin
					cmd.root_rd = 1'b1;
					state_d     = S_F2;
				end
			end
			S_F2: begin
				cmd.acc_ld = 1'b1;
				if (sts.div_need) begin
					cmd.div_go = 1'b1;
					state_d    = S_F3;
				end else begin
					state_d = S_F4;
				end
			end
			S_F3: begin
				if (sts.div_done) begin
					state_d = S_F4;
				end
			end
			S_F4: begin
				cmd.fill_wr = 1'b1;
				if (sts.at_end) begin
					cmd.pos_clr = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_F0;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chg_q   <= 1'b0;
			prev_q  <= 1'b1;
			dir_q   <= DIR_RIGHT;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				chg_q  <= 1'b0;
				prev_q <= 1'b1;
			end else if (state_q == S_P3) begin
				if (sts.at_end) begin
					prev_q <= pass_chg;
					chg_q  <= 1'b0;
				end else begin
					chg_q <= pass_chg;
				end
			end
			if (state_q == S_A2) begin
				dir_q <= DIR_RIGHT;
			end else if (state_q == S_A3) begin
				dir_q <= dir_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_read_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == OP_READ) |=> state_q == S_RD)
		else $error("read beat did not enter the read state");
	a_last_to_init: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == OP_LOAD && in_last) |=> state_q == S_INIT)
		else $error("last load beat did not start the fill");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> (state_q == S_F3 && !sts.div_done))
		else $error("divider start not followed by a busy wait");
	a_dir_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A3 && dir_q != DIR_UP) |=> dir_q == 2'($past(dir_q) + 2'd1))
		else $error("neighbor direction did not advance");
`endif

endmodule
`default_nettype wire
